/* sv/bba_pkg.sv */
// Package for the buddy block allocator: table entry layout, heap geometry
// and command codes. No dependencies.
`default_nettype none

package bba_pkg;

  // Slot size in bytes; a power of two.
  localparam int unsigned MIN_BLOCK  = 32;
  localparam int unsigned MIN_LOG2   = $clog2(MIN_BLOCK);
  localparam int unsigned HEAP_BYTES = 16384;

  // Table entry: allocated flag on top, block size in bytes below it.
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned FLAG_POS = 15;
  // A block size counted in slots.
  localparam int unsigned STEP_W   = SIZE_W - MIN_LOG2;

  localparam logic [SIZE_W-1:0] HEAP_ENTRY    = SIZE_W'(HEAP_BYTES % (2 ** SIZE_W));
  localparam logic [31:0]       HEAP_BASE_RST = 32'h2000_1000;
  // Largest offset from the heap base that a free may name.
  localparam logic [31:0]       FREE_LIMIT    = 32'(HEAP_BYTES - MIN_BLOCK);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

/* sv/buddy_block_allocator.sv */
// Buddy block allocator top level: sequencer, block table memory and the
// heap base register. Depends on bba_pkg.
// An allocate finds the power-of-two fit, scans the table block by block for a free block
// that holds the request and then halves that block until it fits; a failed scan ends without
// halving. A free checks the range, clears the allocated flag and merges with each matching
// buddy in turn. One item at a time; the single read port sets the scan rate of one entry per
// cycle. Results are strobed for one cycle on done_o.
// Reset: a clearing pass (entry 0 the whole heap, free; the rest zero) runs with busy_o
// high; heap_base is reset to 0x20001000 and may be written meanwhile.
`default_nettype none

module buddy_block_allocator #(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: heap base address.
  input  wire logic        heap_base_we_i,
  input  wire logic [31:0] heap_base_i,
  // Command item.
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [31:0] free_address_i,
  // Result item, valid for the one cycle that done_o is high.
  output logic             done_o,
  output logic [31:0]      block_address_o,
  output logic             success_o
);

  localparam int unsigned SIZE_W  = bba_pkg::SIZE_W;
  localparam int unsigned STEP_W  = bba_pkg::STEP_W;
  localparam int unsigned ENTRY_W = bba_pkg::ENTRY_W;
  localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // The scan counter must hold a table index plus one hop without wrapping.
  localparam int unsigned CNT_W   = ((IDX_W > STEP_W) ? IDX_W : STEP_W) + 1;
  localparam logic [CNT_W-1:0] T_CNT    = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIT,
    ST_SCAN,
    ST_SPLIT,
    ST_FCHK,
    ST_FWAIT,
    ST_FCLR,
    ST_FBUD,
    ST_FMRG
  } state_e;

  state_e state_q;

  logic [31:0]        heap_base_q;
  logic [15:0]        req_q;
  logic [31:0]        faddr_q;
  logic [16:0]        fit_q;
  logic [CNT_W-1:0]   i_q;
  logic [CNT_W-1:0]   b_q;
  logic [CNT_W-1:0]   lower_q;
  logic [SIZE_W-1:0]  size_q;
  logic               done_q;
  logic               success_q;
  logic [31:0]        addr_q;

  // Block table: one write port, one registered read port.
  logic [ENTRY_W-1:0] table_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rdata_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_q[waddr] <= wdata;
    end
    rdata_q <= table_q[rd_addr];
  end

  // Fields of the entry read last cycle.
  logic              e_flag;
  logic [SIZE_W-1:0] e_size;
  logic              e_zero;
  assign e_flag = rdata_q[bba_pkg::FLAG_POS];
  assign e_size = rdata_q[SIZE_W-1:0];
  assign e_zero = (rdata_q == '0);

  // Scan: hop to the next block, or step one entry over a zero entry.
  logic [STEP_W-1:0] scan_step;
  logic [CNT_W-1:0]  scan_next;
  logic              scan_hit;
  assign scan_step = e_size[SIZE_W-1:bba_pkg::MIN_LOG2];
  assign scan_next = e_zero ? (i_q + CNT_W'(1)) : (i_q + CNT_W'(scan_step));
  assign scan_hit  = !e_zero && !e_flag && ({1'b0, e_size} >= req_q);

  // Split: the upper half of the current block gets its own entry.
  logic [SIZE_W-1:0] half;
  logic [STEP_W-1:0] half_step;
  logic [CNT_W-1:0]  split_j;
  logic              split_more;
  assign half       = size_q >> 1;
  assign half_step  = half[SIZE_W-1:bba_pkg::MIN_LOG2];
  assign split_j    = i_q + CNT_W'(half_step);
  assign split_more = ({2'b0, size_q} > fit_q);

  // Free range check and slot index.
  logic [32:0] foff;
  logic [31:0] fidx;
  logic        fbad;
  assign foff = {1'b0, faddr_q} - {1'b0, heap_base_q};
  assign fidx = foff[31:0] >> bba_pkg::MIN_LOG2;
  assign fbad = foff[32] || (foff[31:0] > bba_pkg::FREE_LIMIT) ||
                (fidx >= 32'(TABLE_ENTRIES));

  // Shared buddy check, fed from the cleared entry or the merged block.
  logic [SIZE_W-1:0] dbl;
  logic [SIZE_W-1:0] mchk_size;
  logic [CNT_W-1:0]  mchk_ix;
  logic [STEP_W-1:0] mchk_step;
  logic [CNT_W-1:0]  mchk_b;
  logic              mchk_stop;
  assign dbl       = {size_q[SIZE_W-2:0], 1'b0};
  assign mchk_size = (state_q == ST_FMRG) ? dbl : e_size;
  assign mchk_ix   = (state_q == ST_FMRG) ? lower_q : i_q;
  assign mchk_step = mchk_size[SIZE_W-1:bba_pkg::MIN_LOG2];
  assign mchk_b    = mchk_ix ^ CNT_W'(mchk_step);
  assign mchk_stop = (mchk_size == '0) || (mchk_step == '0) || (mchk_b >= T_CNT);

  // Buddy compare against the entry of b_q.
  logic             bud_ok;
  logic [CNT_W-1:0] bud_lower;
  logic [CNT_W-1:0] bud_upper;
  assign bud_ok    = !e_flag && (e_size == size_q);
  assign bud_lower = (b_q < i_q) ? b_q : i_q;
  assign bud_upper = (b_q < i_q) ? i_q : b_q;

  // Read address: the scan and the buddy check look one entry ahead.
  always_comb begin
    case (state_q)
      ST_SCAN:          rd_addr = scan_next[IDX_W-1:0];
      ST_FCLR, ST_FMRG: rd_addr = mchk_b[IDX_W-1:0];
      default:          rd_addr = i_q[IDX_W-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i_q[IDX_W-1:0];
    wdata = '0;
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = (i_q == '0) ? {1'b0, bba_pkg::HEAP_ENTRY} : '0;
      end
      ST_SPLIT: begin
        if (split_more) begin
          we    = (half_step != '0) && (split_j < T_CNT);
          waddr = split_j[IDX_W-1:0];
          wdata = {1'b0, half};
        end else begin
          // The block head takes its final size and the allocated flag.
          we    = 1'b1;
          wdata = {1'b1, size_q};
        end
      end
      ST_FCLR: begin
        we    = 1'b1;
        wdata = {1'b0, e_size};
      end
      ST_FBUD: begin
        we    = bud_ok;
        waddr = bud_upper[IDX_W-1:0];
        wdata = '0;
      end
      ST_FMRG: begin
        we    = 1'b1;
        waddr = lower_q[IDX_W-1:0];
        wdata = {1'b0, dbl};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      heap_base_q <= bba_pkg::HEAP_BASE_RST;
      req_q       <= '0;
      faddr_q     <= '0;
      fit_q       <= '0;
      i_q         <= '0;
      b_q         <= '0;
      lower_q     <= '0;
      size_q      <= '0;
      done_q      <= 1'b0;
      success_q   <= 1'b0;
      addr_q      <= '0;
    end else begin
      done_q    <= 1'b0;
      success_q <= 1'b0;
      addr_q    <= '0;
      if (heap_base_we_i) begin
        heap_base_q <= heap_base_i;
      end
      case (state_q)
        ST_INIT: begin
          if (i_q == LAST_CNT) begin
            state_q <= ST_IDLE;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            req_q   <= request_size_i;
            faddr_q <= free_address_i;
            fit_q   <= 17'(bba_pkg::MIN_BLOCK);
            i_q     <= '0;
            state_q <= (command_i == bba_pkg::CMD_FREE) ? ST_FCHK : ST_FIT;
          end
        end
        ST_FIT: begin
          // Smallest power-of-two multiple of a slot that holds the request.
          if (fit_q < {1'b0, req_q}) begin
            fit_q <= fit_q << 1;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (i_q >= T_CNT) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (scan_hit) begin
            size_q  <= e_size;
            state_q <= ST_SPLIT;
          end else if (!e_zero && (scan_step == '0)) begin
            // An entry smaller than a slot cannot be hopped over.
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            i_q <= scan_next;
          end
        end
        ST_SPLIT: begin
          if (split_more) begin
            size_q <= half;
          end else begin
            done_q    <= 1'b1;
            success_q <= 1'b1;
            addr_q    <= heap_base_q + (32'(i_q) << bba_pkg::MIN_LOG2);
            state_q   <= ST_IDLE;
          end
        end
        ST_FCHK: begin
          if (fbad) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            i_q     <= CNT_W'(fidx);
            state_q <= ST_FWAIT;
          end
        end
        ST_FWAIT: begin
          state_q <= ST_FCLR;
        end
        ST_FCLR: begin
          size_q <= e_size;
          if (mchk_stop) begin
            done_q    <= 1'b1;
            success_q <= 1'b1;
            addr_q    <= faddr_q;
            state_q   <= ST_IDLE;
          end else begin
            b_q     <= mchk_b;
            state_q <= ST_FBUD;
          end
        end
        ST_FBUD: begin
          if (bud_ok) begin
            lower_q <= bud_lower;
            state_q <= ST_FMRG;
          end else begin
            done_q    <= 1'b1;
            success_q <= 1'b1;
            addr_q    <= faddr_q;
            state_q   <= ST_IDLE;
          end
        end
        ST_FMRG: begin
          size_q <= dbl;
          i_q    <= lower_q;
          if (mchk_stop) begin
            done_q    <= 1'b1;
            success_q <= 1'b1;
            addr_q    <= faddr_q;
            state_q   <= ST_IDLE;
          end else begin
            b_q     <= mchk_b;
            state_q <= ST_FBUD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign success_o       = success_q;
  assign block_address_o = addr_q;

  // An accepted command keeps the block busy in the next cycle.
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not make the block busy");

  // A result appears only as the sequencer returns to idle.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while busy");

  // Each result is strobed for a single cycle.
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A failed command reports a zero address.
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (block_address_o == '0))
    else $error("failed command with nonzero address");

  // Success is only reported together with a result.
  a_success_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    success_o |-> done_o)
    else $error("success outside a result");

endmodule

`default_nettype wire

/* bench/tb_buddy_block_allocator.sv */
// Self-checking testbench for buddy_block_allocator: directed rows, then random
// allocate and free traffic over several heap base settings, with a local model.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;

  localparam int unsigned TABLE_ENTRIES = 512;
  // Slowest item: a full table scan plus fit search and splits, plus a
  // sender gap. Taken about four times over for some 1200 items, plus the
  // clearing pass after reset.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam logic [14:0] SIZE_MASK     = 15'h7FFF;
  localparam int unsigned N_PROBES      = 24;

  typedef struct packed {
    logic [31:0] block_address;
    logic        success;
  } reply_t;

  // One row of the directed table. Where known is set, the reply is typed in
  // and is what gets checked; otherwise the local model supplies it.
  typedef struct packed {
    bba_pkg::cmd_e cmd;
    logic [15:0]   size;
    logic [31:0]   addr;
    bit            known;
    logic [31:0]   want_addr;
    logic          want_ok;
  } probe_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        heap_base_we_i;
  logic [31:0] heap_base_i;
  logic        start_i;
  logic        busy_o;
  logic        command_i;
  logic [15:0] request_size_i;
  logic [31:0] free_address_i;
  logic        done_o;
  logic [31:0] block_address_o;
  logic        success_o;

  // Local copy of the block table and the heap base register.
  logic [15:0]  slot_table [TABLE_ENTRIES];
  logic [31:0]  heap_base_q;
  // Replies owed by the block, oldest first.
  reply_t       owed_replies[$];
  // Slots that currently head an allocated block, used to pick sane frees.
  int unsigned  live_slots[$];
  int unsigned  error_count = 0;

  buddy_block_allocator #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .heap_base_we_i (heap_base_we_i),
    .heap_base_i    (heap_base_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .done_o         (done_o),
    .block_address_o(block_address_o),
    .success_o      (success_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Smallest power-of-two block, at least one slot, that holds x bytes.
  function automatic logic [31:0] fit_bytes(input logic [31:0] x);
    logic [31:0] f;
    f = bba_pkg::MIN_BLOCK;
    while (f < x && f < 32'h8000_0000) f = f << 1;
    return f;
  endfunction

  // Allocation: first-fit scan hopping block by block, then halving until the
  // block is the tightest power of two for the request. Returns the slot.
  function automatic bit carve_block(input logic [15:0] req, output int unsigned slot);
    int unsigned i;
    int unsigned sz;
    int unsigned half;
    int unsigned j;
    logic [15:0] e;
    bit          found;
    i = 0;
    sz = 0;
    found = 1'b0;
    slot = 0;
    while (i < TABLE_ENTRIES && !found) begin
      e = slot_table[i];
      if (e == 16'h0) begin
        i++;
      end else begin
        sz = e[14:0];
        if (sz >= req && !e[bba_pkg::FLAG_POS]) begin
          found = 1'b1;
        end else begin
          // A size below one slot cannot be hopped over: the scan gives up.
          if (sz / bba_pkg::MIN_BLOCK == 0) return 1'b0;
          i += sz / bba_pkg::MIN_BLOCK;
        end
      end
    end
    if (!found) return 1'b0;
    while (fit_bytes(sz) > fit_bytes(req)) begin
      half = sz / 2;
      j = i + half / bba_pkg::MIN_BLOCK;
      slot_table[i] = {1'b0, 15'(half) & SIZE_MASK};
      if (j < TABLE_ENTRIES && j != i) slot_table[j] = {1'b0, 15'(half) & SIZE_MASK};
      sz = half;
    end
    slot_table[i][bba_pkg::FLAG_POS] = 1'b1;
    slot = i;
    return 1'b1;
  endfunction

  // Release: range check against the heap window (in 33 bits so a base near
  // the top of the address space does not wrap), clear the flag, then merge
  // with free buddies of equal size for as long as possible.
  function automatic bit release_block(input logic [31:0] addr, output int unsigned slot);
    logic [32:0] lo;
    logic [32:0] hi;
    int unsigned i;
    int unsigned sz;
    int unsigned b;
    int unsigned lower;
    int unsigned upper;
    logic [15:0] be;
    bit          merging;
    lo = {1'b0, heap_base_q};
    hi = lo + 33'(bba_pkg::HEAP_BYTES - bba_pkg::MIN_BLOCK);
    slot = 0;
    if ({1'b0, addr} < lo || {1'b0, addr} > hi) return 1'b0;
    i = int'(({1'b0, addr} - lo) / bba_pkg::MIN_BLOCK);
    if (i >= TABLE_ENTRIES) return 1'b0;
    slot = i;
    slot_table[i][bba_pkg::FLAG_POS] = 1'b0;
    merging = 1'b1;
    while (merging) begin
      sz = slot_table[i][14:0];
      b = i ^ (sz / bba_pkg::MIN_BLOCK);
      if (sz == 0 || b == i || b >= TABLE_ENTRIES) begin
        merging = 1'b0;
      end else begin
        be = slot_table[b];
        if (be[bba_pkg::FLAG_POS] || be[14:0] != sz) begin
          merging = 1'b0;
        end else begin
          lower = (b < i) ? b : i;
          upper = (b < i) ? i : b;
          slot_table[upper] = 16'h0;
          // The doubled size is kept to 15 bits; a wrap to zero ends merging
          // on the next pass through the size check.
          slot_table[lower] = {1'b0, 15'(sz * 2) & SIZE_MASK};
          i = lower;
        end
      end
    end
    return 1'b1;
  endfunction

  // Drives one command item, holds it until the block takes it, then books
  // the reply it owes. start_i is left high: the caller either drives the next
  // item in the same step or lowers it, so start_i sees one assignment a step.
  task automatic send_command(input bba_pkg::cmd_e cmd, input logic [15:0] size,
                              input logic [31:0] addr, input bit known,
                              input logic [31:0] want_addr, input logic want_ok);
    reply_t      reply;
    int unsigned slot;
    bit          ok;
    int          k;
    start_i        <= 1'b1;
    command_i      <= cmd;
    request_size_i <= size;
    free_address_i <= addr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (cmd == bba_pkg::CMD_ALLOC) begin
      ok = carve_block(size, slot);
      reply.block_address = ok ? heap_base_q + 32'(slot * bba_pkg::MIN_BLOCK) : 32'h0;
      if (ok) live_slots.push_back(slot);
    end else begin
      ok = release_block(addr, slot);
      reply.block_address = ok ? addr : 32'h0;
      // Any successful free takes the slot off the live list, including
      // frees of blocks that were already released.
      k = 0;
      while (ok && k < live_slots.size()) begin
        if (live_slots[k] == slot) live_slots.delete(k);
        else k++;
      end
    end
    reply.success = ok;
    if (known) begin
      reply.block_address = want_addr;
      reply.success       = want_ok;
    end
    owed_replies.push_back(reply);
  endtask

  // Stops the sender and waits until the block has answered everything and
  // gone idle. Every item gives a reply, so an empty list means nothing left
  // in flight, apart from the wind-down that the pause covers.
  task automatic drain_block();
    start_i <= 1'b0;
    while (owed_replies.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_heap_base(input logic [31:0] value);
    drain_block();
    heap_base_we_i <= 1'b1;
    heap_base_i    <= value;
    @(posedge clk_i);
    heap_base_we_i <= 1'b0;
    heap_base_q = value;
  endtask

  // Random traffic: mostly allocations of small sizes and frees of live
  // blocks, so the table keeps splitting and merging, with some noise frees
  // (interior slots, already free blocks, addresses outside the window).
  task automatic random_phase(input int unsigned count);
    int unsigned gap;
    int unsigned burst;
    int unsigned pick;
    int unsigned band;
    logic [15:0] size;
    logic [31:0] addr;
    burst = 0;
    repeat (count) begin
      // Now and then hold off until every reply is in.
      if ($urandom_range(0, 59) == 0) drain_block();
      if (burst == 0 && $urandom_range(0, 11) == 0) burst = $urandom_range(10, 40);
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, 17);
      end
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      size = 16'($urandom_range(0, 65535));
      addr = $urandom();
      if (pick < 52) begin
        band = $urandom_range(0, 19);
        if (band < 12)      size = 16'($urandom_range(0, 64));
        else if (band < 17) size = 16'($urandom_range(0, 1024));
        else if (band < 19) size = 16'($urandom_range(1025, bba_pkg::HEAP_BYTES));
        send_command(bba_pkg::CMD_ALLOC, size, addr, 1'b0, 32'h0, 1'b0);
      end else begin
        if (pick < 88 && live_slots.size() > 0) begin
          addr = heap_base_q +
                 32'(live_slots[$urandom_range(0, live_slots.size() - 1)] *
                     bba_pkg::MIN_BLOCK);
          // Sometimes point inside the slot; the offset must be ignored.
          if ($urandom_range(0, 3) == 0) begin
            addr = addr + 32'($urandom_range(0, bba_pkg::MIN_BLOCK - 1));
          end
        end else begin
          band = $urandom_range(0, 3);
          if (band == 1) begin
            addr = heap_base_q +
                   32'($urandom_range(0, TABLE_ENTRIES - 1) * bba_pkg::MIN_BLOCK);
          end else if (band == 2) begin
            addr = heap_base_q - 32'($urandom_range(1, 64));
          end else if (band == 3) begin
            addr = heap_base_q + bba_pkg::FREE_LIMIT + 32'($urandom_range(1, 64));
          end
        end
        send_command(bba_pkg::CMD_FREE, size, addr, 1'b0, 32'h0, 1'b0);
      end
    end
  endtask

  // Reply checker: every strobe must match the oldest owed reply.
  always @(posedge clk_i) begin : check_reply
    reply_t want;
    if (rst_ni && done_o) begin
      if (owed_replies.size() == 0) begin
        $error("unexpected reply: block_address %h success %b", block_address_o, success_o);
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        if (block_address_o !== want.block_address) begin
          $error("block_address: expected %h, got %h", want.block_address, block_address_o);
          error_count++;
        end
        if (success_o !== want.success) begin
          $error("success: expected %b, got %b", want.success, success_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_buddy_block_allocator: FAIL");
    $finish;
  end

  initial begin : stimulus
    probe_row_t  probe_rows [N_PROBES];
    logic [31:0] phase_base [4];
    int unsigned phase_len  [5];
    int unsigned r;

    heap_base_we_i <= 1'b0;
    heap_base_i    <= 32'h0;
    start_i        <= 1'b0;
    command_i      <= bba_pkg::CMD_ALLOC;
    request_size_i <= 16'h0;
    free_address_i <= 32'h0;

    // Model state after reset: the whole heap as one free block at slot 0.
    for (int s = 0; s < TABLE_ENTRIES; s++) slot_table[s] = 16'h0;
    slot_table[0] = {1'b0, bba_pkg::HEAP_ENTRY};
    heap_base_q   = bba_pkg::HEAP_BASE_RST;

    // Directed rows. The first group follows from the reset state: a minimum
    // block at slot 0, oversize and full-heap failures, the full merge back,
    // offsets inside a slot, both edges of the free window, a free of an
    // empty entry and of a block that is already free. The second group
    // splits and merges at several sizes and is checked by the model.
    probe_rows = '{
      '{bba_pkg::CMD_ALLOC, 16'd0, 32'hFFFF_FFFF, 1'b1, bba_pkg::HEAP_BASE_RST, 1'b1},
      '{bba_pkg::CMD_ALLOC, 16'hFFFF, 32'h0, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd16384, 32'h0, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'hFFFF, bba_pkg::HEAP_BASE_RST, 1'b1,
        bba_pkg::HEAP_BASE_RST, 1'b1},
      '{bba_pkg::CMD_ALLOC, 16'd16384, 32'h0, 1'b1, bba_pkg::HEAP_BASE_RST, 1'b1},
      '{bba_pkg::CMD_ALLOC, 16'd1, 32'h0, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + 32'd31, 1'b1,
        bba_pkg::HEAP_BASE_RST + 32'd31, 1'b1},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST, 1'b1,
        bba_pkg::HEAP_BASE_RST, 1'b1},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST - 32'd1, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + bba_pkg::FREE_LIMIT + 32'd1,
        1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, 32'h0, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + bba_pkg::FREE_LIMIT, 1'b1,
        bba_pkg::HEAP_BASE_RST + bba_pkg::FREE_LIMIT, 1'b1},
      '{bba_pkg::CMD_ALLOC, 16'd32, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd33, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd100, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd8192, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd8193, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + 32'd64, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + 32'd160, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_ALLOC, 16'd16, 32'h0, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + 32'd8192, 1'b0, 32'h0, 1'b0},
      '{bba_pkg::CMD_FREE, 16'd0, bba_pkg::HEAP_BASE_RST + 32'd128, 1'b0, 32'h0, 1'b0}
    };

    // Heap base settings after the reset one: both ends of the address space,
    // the highest base whose window still fits in 32 bits, and a random one.
    phase_base = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_C000, 32'h0};
    phase_len  = '{300, 250, 120, 250, 230};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block sits in its clearing pass now; the first item simply waits.
    foreach (probe_rows[n]) begin
      r = $urandom_range(0, 17);
      if (r > 0) begin
        start_i <= 1'b0;
        repeat (r) @(posedge clk_i);
      end
      send_command(probe_rows[n].cmd, probe_rows[n].size, probe_rows[n].addr,
                   probe_rows[n].known, probe_rows[n].want_addr, probe_rows[n].want_ok);
    end
    random_phase(phase_len[0]);

    for (int p = 1; p < 5; p++) begin
      write_heap_base((p == 4) ? $urandom() : phase_base[p-1]);
      random_phase(phase_len[p]);
    end

    start_i <= 1'b0;
    while (owed_replies.size() > 0) @(posedge clk_i);
    // Wait on so that a stray strobe is still caught.
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_buddy_block_allocator: PASS");
    end else begin
      $display("tb_buddy_block_allocator: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bba_pkg.sv
sv/buddy_block_allocator.sv
bench/tb_buddy_block_allocator.sv
